FILE: design/ppe_pkg.sv
// Shared types, codes, reset values and helpers for the particle pool engine.
package ppe_pkg;

  localparam int DEF_POOL_SIZE = 64;

  localparam logic [23:0]        RST_GRAVITY  = 24'd61440;
  localparam logic signed [23:0] RST_FLOOR    = 24'sd410;
  localparam logic [15:0]        RST_BOUNCE   = 16'd19661;
  localparam logic [15:0]        RST_FRICTION = 16'd52429;

  localparam logic [7:0]  ALPHA_MAX = 8'd255;
  // ceil(2^23 / 255): floor(x*RECIP_255 / 2^23) is x/255 or one above for x < 2^24
  localparam logic signed [17:0] RECIP_255 = 18'sd32897;

  typedef enum logic [1:0] {
    REQ_SPAWN = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_DRAW  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DRAWN   = 2'd0,
    ST_SPAWNED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_GRAVITY  = 2'd0,
    REG_FLOOR    = 2'd1,
    REG_BOUNCE   = 2'd2,
    REG_FRICTION = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic [15:0]        life_left;
    logic [15:0]        life_init;
    logic [15:0]        size;
    logic [23:0]        rgb;
  } slot_rec_t;

  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [15:0] den;
  } div_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    hi = 28'sd8388607;
    lo = -28'sd8388608;
    if (v > hi) return 24'sh7FFFFF;
    if (v < lo) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

FILE: design/ppe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ppe_mul.sv
// Shared signed multiplier with registered product.
module ppe_mul (
  input  logic               clk,
  input  logic signed [24:0] a,
  input  logic signed [17:0] b,
  output logic signed [42:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: design/ppe_div.sv
// Restoring divider, one quotient bit per cycle, 8 quotient bits.
module ppe_div (
  input  logic               clk,
  input  logic               rst,
  input  ppe_pkg::div_req_t  req,
  output logic               busy,
  output logic [7:0]         quot
);
  import ppe_pkg::*;

  logic [15:0] rem;
  logic [15:0] den;
  logic [7:0]  shreg;
  logic [3:0]  cnt;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  assign trial = {rem, shreg[7]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 4'd8;
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den   <= req.den;
      quot  <= '0;
      // top bits are known smaller than the divisor
      rem   <= req.num[23:8];
      shreg <= req.num[7:0];
    end else if (busy) begin
      rem   <= fits ? diff[15:0] : trial[15:0];
      shreg <= {shreg[6:0], 1'b0};
      quot  <= {quot[6:0], fits};
    end
  end

endmodule

FILE: design/particle_pool_physics_engine.sv
// Particle pool engine: spawn, Euler tick and draw over a shared multiplier and divider.
// Spawn: one result after a slot scan, one slot a cycle.
// Tick: scan of all slots, a load, move and store per active slot, three more products per slot on floor contact.
// Draw: one slot a cycle while scanning; per active slot an 8-bit pass through the
// shared divider (skipped at full alpha), plus wait on out_stall.
// Reset: active flags cleared at once, registers to defaults; slot store left as is.
module particle_pool_physics_engine #(
  parameter int POOL_SIZE = ppe_pkg::DEF_POOL_SIZE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [23:0] spawn_x,
  input  logic signed [23:0] spawn_y,
  input  logic signed [23:0] spawn_z,
  input  logic signed [23:0] speed_x,
  input  logic signed [23:0] speed_y,
  input  logic signed [23:0] speed_z,
  input  logic [23:0]        tint_rgb,
  input  logic [15:0]        life_span,
  input  logic [15:0]        radius,
  input  logic [15:0]        time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [23:0] draw_x,
  output logic signed [23:0] draw_y,
  output logic signed [23:0] draw_z,
  output logic [15:0]        draw_size,
  output logic [23:0]        draw_rgb,
  output logic [7:0]         alpha,
  output logic               last
);
  import ppe_pkg::*;

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int IW = $clog2(POOL_SIZE + 1);
  localparam int RW = $bits(slot_rec_t);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_MOVE  = 7'b0001000,
    S_STORE = 7'b0010000,
    S_DRAW  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [23:0]        gravity;
  logic signed [23:0] floor_h;
  logic [15:0]        bounce;
  logic [15:0]        friction;

  // latched request
  req_t      req_q;
  slot_rec_t spawn_rec;
  logic [15:0] dt_q;

  // pool control
  logic [POOL_SIZE-1:0] active;
  logic [IW-1:0]        idx;
  logic [AW-1:0]        slot;
  logic                 at_end;
  logic                 more_after;

  // working slot
  slot_rec_t rec;
  logic [3:0] step;
  logic [7:0] alpha_q;
  logic       alive;

  // shared units
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] mul_p;
  div_req_t           div_req;
  logic               div_busy;
  logic [7:0]         div_quot;

  // memory port
  logic      ram_we;
  slot_rec_t ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic spawn_hit;

  // arithmetic on the product
  logic signed [23:0] pos_src;
  logic signed [27:0] pos_sum;
  logic signed [27:0] grav_dif;
  logic signed [42:0] neg_p;
  logic signed [27:0] bounce_v;
  logic signed [27:0] fric_v;
  logic signed [16:0] life_dif;

  // size*alpha/255 by reciprocal product and one correction
  logic [23:0] sz_prod;
  logic [16:0] sz_est;
  logic [24:0] sz_back;
  logic [15:0] sz_q;

  assign in_stall = (state != S_IDLE);
  assign slot     = idx[AW-1:0];
  assign at_end   = (idx == IW'(POOL_SIZE));

  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < POOL_SIZE; j++) begin
      if (IW'(j) > idx && active[j]) more_after = 1'b1;
    end
  end

  assign spawn_hit = (state == S_SCAN) && (req_q == REQ_SPAWN) && !at_end && !active[slot];
  assign ram_we    = spawn_hit || (state == S_STORE);
  assign ram_wdata = spawn_hit ? spawn_rec : rec;

  ppe_ram #(
    .WIDTH (RW),
    .DEPTH (POOL_SIZE),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // multiplier operand select; the product is registered and used at the next step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MOVE) begin
      case (step)
        4'd0: begin mul_a = {rec.vx[23], rec.vx}; mul_b = {2'b0, dt_q}; end
        4'd1: begin mul_a = {rec.vy[23], rec.vy}; mul_b = {2'b0, dt_q}; end
        4'd2: begin mul_a = {rec.vz[23], rec.vz}; mul_b = {2'b0, dt_q}; end
        4'd3: begin mul_a = {1'b0, gravity};      mul_b = {2'b0, dt_q}; end
        4'd5: begin mul_a = {rec.vy[23], rec.vy}; mul_b = {2'b0, bounce}; end
        4'd6: begin mul_a = {rec.vx[23], rec.vx}; mul_b = {2'b0, friction}; end
        4'd7: begin mul_a = {rec.vz[23], rec.vz}; mul_b = {2'b0, friction}; end
        default: ;
      endcase
    end else if (state == S_DRAW) begin
      case (step)
        4'd0: begin mul_a = {9'd0, rec.life_left}; mul_b = 18'sd255; end
        4'd3: begin mul_a = {9'd0, rec.size};      mul_b = {10'd0, alpha_q}; end
        4'd4: begin mul_a = {1'b0, mul_p[23:0]};   mul_b = RECIP_255; end
        default: ;
      endcase
    end
  end

  ppe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    div_req.start = (state == S_DRAW) && (step == 4'd1);
    div_req.num   = mul_p[23:0];
    div_req.den   = rec.life_init;
  end

  ppe_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .quot (div_quot)
  );

  // floor shift by 16 is the top bits of the product
  always_comb begin
    case (step)
      4'd1:    pos_src = rec.px;
      4'd2:    pos_src = rec.py;
      default: pos_src = rec.pz;
    endcase
    pos_sum  = {{4{pos_src[23]}}, pos_src} + {mul_p[42], mul_p[42:16]};
    grav_dif = {{4{rec.vy[23]}}, rec.vy} - {1'b0, mul_p[42:16]};
    neg_p    = -mul_p;
    bounce_v = {neg_p[42], neg_p[42:16]};
    fric_v   = {mul_p[42], mul_p[42:16]};
    life_dif = {1'b0, rec.life_left} - {5'd0, dt_q[15:4]};
  end

  // estimate is exact or one high; step back when estimate*255 overshoots
  always_comb begin
    sz_est  = mul_p[39:23];
    sz_back = {sz_est, 8'd0} - {8'd0, sz_est};
    sz_q    = (sz_back > {1'b0, sz_prod}) ? 16'(sz_est - 17'd1) : sz_est[15:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity  <= RST_GRAVITY;
      floor_h  <= RST_FLOOR;
      bounce   <= RST_BOUNCE;
      friction <= RST_FRICTION;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GRAVITY:  gravity  <= cfg_data;
        REG_FLOOR:    floor_h  <= cfg_data;
        REG_BOUNCE:   bounce   <= cfg_data[15:0];
        REG_FRICTION: friction <= cfg_data[15:0];
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      step      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q <= req_t'(req_type);
            spawn_rec <= '{px: spawn_x, py: spawn_y, pz: spawn_z,
                           vx: speed_x, vy: speed_y, vz: speed_z,
                           life_left: life_span, life_init: life_span,
                           size: radius, rgb: tint_rgb};
            dt_q <= time_step;
            idx  <= '0;
            unique case (req_t'(req_type))
              REQ_SPAWN, REQ_TICK: state <= S_SCAN;
              REQ_DRAW: begin
                if (active == '0) begin
                  // nothing to draw: one empty result
                  status    <= ST_EMPTY;
                  draw_x    <= '0;
                  draw_y    <= '0;
                  draw_z    <= '0;
                  draw_size <= '0;
                  draw_rgb  <= '0;
                  alpha     <= '0;
                  last      <= 1'b1;
                  out_valid <= 1'b1;
                  state     <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              REQ_NONE: state <= S_IDLE;
            endcase
          end
        end

        S_SCAN: begin
          if (at_end) begin
            if (req_q == REQ_SPAWN) begin
              status    <= ST_FULL;
              draw_x    <= '0;
              draw_y    <= '0;
              draw_z    <= '0;
              draw_size <= '0;
              draw_rgb  <= '0;
              alpha     <= '0;
              last      <= 1'b1;
              out_valid <= 1'b1;
              state     <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else if (req_q == REQ_SPAWN) begin
            if (!active[slot]) begin
              active[slot] <= 1'b1;
              status    <= ST_SPAWNED;
              draw_x    <= '0;
              draw_y    <= '0;
              draw_z    <= '0;
              draw_size <= '0;
              draw_rgb  <= '0;
              alpha     <= '0;
              last      <= 1'b1;
              out_valid <= 1'b1;
              state     <= S_EMIT;
            end else begin
              idx <= idx + IW'(1);
            end
          end else if (active[slot]) begin
            state <= S_LOAD;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        S_LOAD: begin
          rec   <= slot_rec_t'(ram_rdata);
          step  <= '0;
          state <= (req_q == REQ_TICK) ? S_MOVE : S_DRAW;
        end

        S_MOVE: begin
          step <= step + 4'd1;
          case (step)
            4'd1: rec.px <= sat24(pos_sum);
            4'd2: rec.py <= sat24(pos_sum);
            4'd3: rec.pz <= sat24(pos_sum);
            4'd4: begin
              rec.vy <= sat24(grav_dif);
              if (life_dif <= 17'sd0) begin
                rec.life_left <= '0;
                alive         <= 1'b0;
              end else begin
                rec.life_left <= life_dif[15:0];
                alive         <= 1'b1;
              end
              // floor contact: clamp, then bounce and damp over three products
              if (rec.py < floor_h) begin
                rec.py <= floor_h;
              end else begin
                state <= S_STORE;
              end
            end
            4'd6: rec.vy <= sat24(bounce_v);
            4'd7: rec.vx <= sat24(fric_v);
            4'd8: begin
              rec.vz <= sat24(fric_v);
              state  <= S_STORE;
            end
            default: ;
          endcase
        end

        S_STORE: begin
          active[slot] <= alive;
          idx   <= idx + IW'(1);
          state <= S_SCAN;
        end

        S_DRAW: begin
          case (step)
            4'd0: begin
              if (rec.life_init == '0) begin
                alpha_q <= (rec.life_left != '0) ? ALPHA_MAX : 8'd0;
                step    <= 4'd3;
              end else if (rec.life_left >= rec.life_init) begin
                alpha_q <= ALPHA_MAX;
                step    <= 4'd3;
              end else begin
                step <= 4'd1;
              end
            end
            4'd2: begin
              if (!div_busy) begin
                alpha_q <= div_quot;
                step    <= 4'd3;
              end
            end
            4'd4: begin
              // hold size*alpha for the correction step
              sz_prod <= mul_p[23:0];
              step    <= step + 4'd1;
            end
            4'd5: begin
              status    <= ST_DRAWN;
              draw_x    <= rec.px;
              draw_y    <= rec.py;
              draw_z    <= rec.pz;
              draw_size <= sz_q;
              draw_rgb  <= rec.rgb;
              alpha     <= alpha_q;
              last      <= !more_after;
              out_valid <= 1'b1;
              state     <= S_EMIT;
            end
            default: step <= step + 4'd1;
          endcase
        end

        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_SCAN;
            end
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");

  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT)
    else $error("result valid outside emit state");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

  a_store_only_tick: assert property (@(posedge clk) disable iff (rst)
    state == S_STORE |-> req_q == REQ_TICK)
    else $error("slot write-back outside tick");
`endif

endmodule
